>>> sv/dedup_insertion_set_unit_assert.svh
// Assertion macros for the dedup insertion set unit.
// Used by the port checker; depends on nothing else.
`ifndef DEDUP_INSERTION_SET_UNIT_ASSERT_SVH
`define DEDUP_INSERTION_SET_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define DIS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("dis assertion failed");

// Next-cycle implication under reset.
`define DIS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("dis assertion failed");

`endif

>>> sv/dis_pkg.sv
// Shared types and codes for the dedup insertion set unit.
// Used by the cell and the top level; depends on nothing.
package dis_pkg;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned CNT_OUT_W = 7;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_PRESENT  = 3'd0,
        ST_ADDED    = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ     = 3'd3,
        ST_PAST_END = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] aux;
        logic [IDX_W-1:0] idx;
        logic             found;
        logic             hit;
        logic [KEY_W-1:0] rkey;
        logic [KEY_W-1:0] raux;
    } t_tok;

endpackage

>>> sv/dis_cell.sv
// One storage cell of the set: holds an entry and passes the transaction on.
// Depends on dis_pkg.
module dis_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [CW-1:0] i_count,
    input  dis_pkg::t_tok i_tok,
    output dis_pkg::t_tok o_tok
);

    logic [dis_pkg::KEY_W-1:0] r_key;
    logic [dis_pkg::KEY_W-1:0] r_aux;
    dis_pkg::t_tok             r_tok;
    dis_pkg::t_tok             n_tok;
    logic                      w_live;
    logic                      w_write;

    always_comb begin
        w_live  = 32'(IDX) < 32'(i_count);
        n_tok   = i_tok;
        w_write = i_tok.valid && (i_tok.op == dis_pkg::OP_ADD) && !i_tok.found
                  && (32'(IDX) == 32'(i_count));
        if (w_live && (i_tok.op == dis_pkg::OP_ADD) && (r_key == i_tok.key)) begin
            n_tok.found = 1'b1;
        end
        if (w_live && (i_tok.op == dis_pkg::OP_READ)
            && (32'(i_tok.idx) == 32'(IDX))) begin
            n_tok.hit  = 1'b1;
            n_tok.rkey = r_key;
            n_tok.raux = r_aux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok.valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok.op    <= n_tok.op;
            r_tok.key   <= n_tok.key;
            r_tok.aux   <= n_tok.aux;
            r_tok.idx   <= n_tok.idx;
            r_tok.found <= n_tok.found;
            r_tok.hit   <= n_tok.hit;
            r_tok.rkey  <= n_tok.rkey;
            r_tok.raux  <= n_tok.raux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_write) begin
            r_key <= i_tok.key;
            r_aux <= i_tok.aux;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> sv/dedup_insertion_set_unit.sv
// Top level of the dedup insertion set unit: cell chain, entry count, output register.
// Depends on dis_pkg and dis_cell.
//
// Usage:
//   Slave channel takes one transaction: opcode in tuser (add, read, clear),
//   key, aux word and entry index in tdata. Master channel returns one result
//   per transaction: status in tuser; entry key, aux word and entry count in tdata.
//   Each transaction walks the chain of CAPACITY cells, one cell per cycle while the chain is not frozen.
//   Every live cell compares an added key with its entry, the cell at the fill
//   position stores a new key, and the addressed cell hands out its entry on a read.
//   One transaction is in the chain at a time: a new one is taken only after
//   the last one leaves the chain end.
//   A new transaction is taken while an earlier result still waits.
//   Receiver stall: a finished transaction holds at the chain end and the
//   whole chain freezes until the output register frees.
//   Reset: empty set, no result pending, no clearing pass.
module dedup_insertion_set_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,   // key_value[63:0], aux_word[127:64],
                                      // entry_index[133:128], zero pad
    input  logic [1:0]   i_s_tuser,   // opcode[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,   // entry_key[63:0], entry_aux[127:64],
                                      // entry_count[134:128], zero pad
    output logic [2:0]   o_m_tuser    // status[2:0]
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    dis_pkg::t_tok             w_tok [0:CAPACITY];
    dis_pkg::t_tok             w_head;
    logic                      w_en;
    logic                      w_exit;
    logic                      w_accept;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_busy;
    logic                      r_out_valid;
    dis_pkg::t_status          r_status;
    dis_pkg::t_status          n_status;
    logic [dis_pkg::KEY_W-1:0] r_out_key;
    logic [dis_pkg::KEY_W-1:0] r_out_aux;
    logic [CW-1:0]             r_out_count;

    assign o_s_tready = !r_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_exit     = w_tok[CAPACITY].valid && (!r_out_valid || i_m_tready);
    assign w_en       = !(w_tok[CAPACITY].valid && r_out_valid && !i_m_tready);

    always_comb begin
        w_head       = '0;
        w_head.valid = w_accept;
        w_head.op    = i_s_tuser;
        w_head.key   = i_s_tdata[63:0];
        w_head.aux   = i_s_tdata[127:64];
        w_head.idx   = i_s_tdata[133:128];
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dis_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = dis_pkg::ST_PAST_END;
        unique case (w_tok[CAPACITY].op)
            dis_pkg::OP_ADD: begin
                if (w_tok[CAPACITY].found) begin
                    n_status = dis_pkg::ST_PRESENT;
                end else if (32'(r_count) >= CAPACITY) begin
                    n_status = dis_pkg::ST_FULL;
                end else begin
                    n_status = dis_pkg::ST_ADDED;
                    n_count  = r_count + CW'(1);
                end
            end
            dis_pkg::OP_READ: begin
                n_status = w_tok[CAPACITY].hit ? dis_pkg::ST_READ : dis_pkg::ST_PAST_END;
            end
            dis_pkg::OP_CLEAR: begin
                n_status = dis_pkg::ST_CLEARED;
                n_count  = '0;
            end
            default: begin
                n_status = dis_pkg::ST_PAST_END;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exit) begin
                r_busy <= 1'b0;
            end
            if (w_exit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit) begin
            r_status    <= n_status;
            r_out_count <= n_count;
            if (w_tok[CAPACITY].op == dis_pkg::OP_READ && w_tok[CAPACITY].hit) begin
                r_out_key <= w_tok[CAPACITY].rkey;
                r_out_aux <= w_tok[CAPACITY].raux;
            end else begin
                r_out_key <= '0;
                r_out_aux <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {1'b0, dis_pkg::CNT_OUT_W'(r_out_count), r_out_aux, r_out_key};

endmodule

>>> sv/dis_chk.sv
// Port checker for the dedup insertion set unit, bound to the top level.
// Depends on dis_pkg and dedup_insertion_set_unit_assert.svh.
`include "dedup_insertion_set_unit_assert.svh"

module dis_chk #(
    parameter int unsigned CAPACITY = 64
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [135:0] i_s_tdata,
    input logic [1:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [135:0] o_m_tdata,
    input logic [2:0]   o_m_tuser
);

    logic w_s_acc;
    logic w_stall;
    logic w_not_read;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_stall    = o_m_tvalid && !i_m_tready;
    assign w_not_read = o_m_tuser != dis_pkg::ST_READ;

    `DIS_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, w_stall,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
    `DIS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_s_acc, !o_s_tready)
    `DIS_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, o_m_tvalid,
        (32'(o_m_tdata[134:128]) <= CAPACITY) || (CAPACITY > 127))
    `DIS_ASSERT_IMPLY(a_zero_data, i_clk, i_rst_n, o_m_tvalid && w_not_read,
        (o_m_tdata[127:0] == 128'd0) && (o_m_tuser <= dis_pkg::ST_CLEARED))

endmodule

bind dedup_insertion_set_unit dis_chk #(.CAPACITY(CAPACITY)) u_dis_chk (.*);
